// ===== rtl/core/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int unsigned HEAP_WORDS       = 65536;
   localparam int unsigned SEARCH_MIN_WORDS = 1024;

   localparam int unsigned BYTE_W   = 13;
   localparam int unsigned FADDR_W  = 16;
   localparam int unsigned PADDR_W  = 16;
   localparam int unsigned NEED_W   = 12;
   localparam int unsigned REQ_W    = 32;
   localparam int unsigned RSP_W    = 24;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic ST_OK      = 1'b0;
   localparam logic ST_NOSPACE = 1'b1;

   typedef enum logic [3:0] {
      SP_IDLE,
      SP_A_RD,
      SP_A_EVAL,
      SP_A_HDR,
      SP_F_RD,
      SP_F_EVAL,
      SP_F_RD2,
      SP_F_WR,
      SP_RSP,
      SP_CLR
   } step_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_RD_H,
      MEM_RD_NXT,
      MEM_WR_CLR,
      MEM_WR_FIT,
      MEM_WR_HDR,
      MEM_WR_FREE
   } mem_op_type;

   typedef enum logic [2:0] {
      CD_DISPATCH,
      CD_ALWAYS,
      CD_ALLOC,
      CD_NXT_OK,
      CD_RSP_FREE,
      CD_CLR_DONE
   } cond_type;

   typedef struct packed {
      mem_op_type mem_op;
      cond_type   cond;
      step_type   jump;
      step_type   alt;
   } ctrl_type;

   // Control store. Most steps go to jump when their condition holds, else to alt; free dispatch and alloc eval differ.
   function automatic ctrl_type ucode(step_type step);
      ctrl_type c;
      c = '{mem_op: MEM_NONE, cond: CD_ALWAYS, jump: SP_IDLE, alt: SP_IDLE};
      case (step)
         SP_IDLE:   c = '{MEM_NONE,    CD_DISPATCH, SP_A_RD,   SP_IDLE};
         SP_A_RD:   c = '{MEM_RD_H,    CD_ALWAYS,   SP_A_EVAL, SP_A_EVAL};
         SP_A_EVAL: c = '{MEM_WR_FIT,  CD_ALLOC,    SP_A_RD,   SP_A_HDR};
         SP_A_HDR:  c = '{MEM_WR_HDR,  CD_ALWAYS,   SP_RSP,    SP_RSP};
         SP_F_RD:   c = '{MEM_RD_H,    CD_ALWAYS,   SP_F_EVAL, SP_F_EVAL};
         SP_F_EVAL: c = '{MEM_NONE,    CD_NXT_OK,   SP_F_RD2,  SP_F_WR};
         SP_F_RD2:  c = '{MEM_RD_NXT,  CD_ALWAYS,   SP_F_WR,   SP_F_WR};
         SP_F_WR:   c = '{MEM_WR_FREE, CD_ALWAYS,   SP_RSP,    SP_RSP};
         SP_RSP:    c = '{MEM_NONE,    CD_RSP_FREE, SP_IDLE,   SP_RSP};
         SP_CLR:    c = '{MEM_WR_CLR,  CD_CLR_DONE, SP_IDLE,   SP_CLR};
         default:   c = '{MEM_NONE,    CD_ALWAYS,   SP_IDLE,   SP_IDLE};
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Ports                         Payload
// req       req_tvalid/tready/tdata/tuser  tuser: opcode; tdata: byte_count, free_address
// rsp       rsp_tvalid/tready/tdata        tdata: payload_address, status
//
// After reset a clearing pass writes every heap word, with req_tready low.
// Allocate reads and evaluates each block header in turn, and writes a new header after a split;
// free reads the header, and the next one when it lies in the heap, then writes; a bad address goes to the response.
// The heap memory has one read and one write per cycle; the header walk sets the allocate time.
// A finished request waits in the output register while the next one is accepted and worked on.

module first_fit_heap_allocator #(
   parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [12:0] byte_count, [28:13] free_address, [31:29] zero
   input  logic [ffha_pkg::REQ_W-1:0]  req_tdata,
   // [0] opcode
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [15:0] payload_address, [16] status, [23:17] zero
   output logic [ffha_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int unsigned AW = $clog2(HEAP_WORDS);
   localparam int unsigned EW = (AW + 1 < 17) ? 17 : AW + 1;
   localparam logic [EW-1:0] HEAP_E = EW'(HEAP_WORDS);
   localparam logic [ffha_pkg::NEED_W-1:0] SMIN = ffha_pkg::NEED_W'(ffha_pkg::SEARCH_MIN_WORDS);

   ffha_pkg::step_type upc_ff, upc_in;
   ffha_pkg::ctrl_type ctrl;

   logic [AW:0]   mem [HEAP_WORDS];
   logic [AW:0]   rd_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW:0]   wr_data;

   logic [AW-1:0] clr_ff, clr_in;
   logic [ffha_pkg::NEED_W-1:0] need_ff, want_ff;
   logic [AW-1:0] h_ff, sz_ff, nxt_ff;
   logic          nxt_ok_ff;
   logic [ffha_pkg::PADDR_W-1:0] res_addr_ff;
   logic          res_status_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::PADDR_W-1:0] rsp_addr_ff;
   logic          rsp_status_ff;

   logic          accept;
   logic          rsp_free;
   logic [ffha_pkg::BYTE_W-1:0]  req_bytes;
   logic [ffha_pkg::FADDR_W-1:0] req_addr;
   logic [ffha_pkg::BYTE_W:0]    bytes_up;
   logic [ffha_pkg::NEED_W-1:0]  need_raw, need_c, want_c;
   logic          addr_ok;
   logic [EW-1:0] addr_e, addr_m1;

   logic [AW-1:0] rd_sz;
   logic          rd_flag;
   logic [EW-1:0] h_e, sz_e, need_e, want_e;
   logic [EW-1:0] hdr_end, h_plus1, split_at, remain;
   logic          past, at_end, hit, exact;
   logic [EW-1:0] f_nxt, merge_end, merged;
   logic          nxt_lt, merge;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (upc_ff == ffha_pkg::SP_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_addr_ff};

   assign req_bytes = req_tdata[ffha_pkg::BYTE_W-1:0];
   assign req_addr  = req_tdata[ffha_pkg::BYTE_W +: ffha_pkg::FADDR_W];
   assign bytes_up  = {1'b0, req_bytes} + (ffha_pkg::BYTE_W + 1)'(3);
   assign need_raw  = bytes_up[ffha_pkg::BYTE_W:2];
   assign need_c    = (need_raw == '0) ? ffha_pkg::NEED_W'(1) : need_raw;
   assign want_c    = (need_c > SMIN) ? need_c : SMIN;
   assign addr_e    = EW'(req_addr);
   assign addr_m1   = addr_e - EW'(1);
   assign addr_ok   = (req_addr != '0) && (addr_e < HEAP_E);

   assign rd_sz    = rd_ff[AW-1:0];
   assign rd_flag  = rd_ff[AW];
   assign h_e      = EW'(h_ff);
   assign sz_e     = EW'(rd_sz);
   assign need_e   = EW'(need_ff);
   assign want_e   = EW'(want_ff);
   assign h_plus1  = h_e + EW'(1);
   assign hdr_end  = h_plus1 + sz_e;
   assign split_at = h_plus1 + need_e;
   assign remain   = sz_e - need_e - EW'(1);
   assign past     = hdr_end > HEAP_E;
   assign at_end   = hdr_end == HEAP_E;
   assign hit      = !rd_flag && (sz_e >= want_e);
   assign exact    = sz_e == need_e;

   assign f_nxt     = hdr_end;
   assign nxt_lt    = f_nxt < HEAP_E;
   assign merge_end = EW'(nxt_ff) + EW'(1) + sz_e;
   assign merge     = nxt_ok_ff && !rd_flag && (merge_end <= HEAP_E);
   assign merged    = EW'(sz_ff) + EW'(1) + sz_e;

   assign clr_in = (upc_ff == ffha_pkg::SP_CLR) ? clr_ff + AW'(1) : clr_ff;
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready)
                      || (upc_ff == ffha_pkg::SP_RSP && rsp_free);

   always_comb begin
      ctrl    = ffha_pkg::ucode(upc_ff);
      rd_en   = 1'b0;
      rd_addr = h_ff;
      wr_en   = 1'b0;
      wr_addr = h_ff;
      wr_data = '0;
      case (ctrl.mem_op)
         ffha_pkg::MEM_RD_H: begin
            rd_en = 1'b1;
         end
         ffha_pkg::MEM_RD_NXT: begin
            rd_en   = 1'b1;
            rd_addr = nxt_ff;
         end
         ffha_pkg::MEM_WR_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? {1'b0, AW'(HEAP_WORDS - 1)} : '0;
         end
         ffha_pkg::MEM_WR_FIT: begin
            wr_en = !past && hit;
            if (exact) begin
               wr_data = {1'b1, rd_sz};
            end else begin
               wr_addr = split_at[AW-1:0];
               wr_data = {1'b0, remain[AW-1:0]};
            end
         end
         ffha_pkg::MEM_WR_HDR: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, need_e[AW-1:0]};
         end
         ffha_pkg::MEM_WR_FREE: begin
            wr_en   = 1'b1;
            wr_data = {1'b0, merge ? merged[AW-1:0] : sz_ff};
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase

      upc_in = upc_ff;
      case (ctrl.cond)
         ffha_pkg::CD_DISPATCH: begin
            if (accept) begin
               if (req_tuser == ffha_pkg::OP_ALLOC) begin
                  upc_in = ctrl.jump;
               end else begin
                  upc_in = addr_ok ? ffha_pkg::SP_F_RD : ffha_pkg::SP_RSP;
               end
            end
         end
         ffha_pkg::CD_ALWAYS: begin
            upc_in = ctrl.jump;
         end
         ffha_pkg::CD_ALLOC: begin
            if (past || (hit && exact) || (!hit && at_end)) begin
               upc_in = ffha_pkg::SP_RSP;
            end else if (hit) begin
               upc_in = ctrl.alt;
            end else begin
               upc_in = ctrl.jump;
            end
         end
         ffha_pkg::CD_NXT_OK: begin
            upc_in = nxt_lt ? ctrl.jump : ctrl.alt;
         end
         ffha_pkg::CD_RSP_FREE: begin
            upc_in = rsp_free ? ctrl.jump : ctrl.alt;
         end
         ffha_pkg::CD_CLR_DONE: begin
            upc_in = (clr_ff == AW'(HEAP_WORDS - 1)) ? ctrl.jump : ctrl.alt;
         end
         default: begin
            upc_in = ffha_pkg::SP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= ffha_pkg::SP_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         need_ff       <= need_c;
         want_ff       <= want_c;
         h_ff          <= (req_tuser == ffha_pkg::OP_ALLOC) ? '0 : addr_m1[AW-1:0];
         res_addr_ff   <= '0;
         res_status_ff <= ffha_pkg::ST_OK;
      end
      if (upc_ff == ffha_pkg::SP_A_EVAL) begin
         if (!past && hit) begin
            res_addr_ff   <= h_plus1[ffha_pkg::PADDR_W-1:0];
            res_status_ff <= ffha_pkg::ST_OK;
         end else begin
            res_addr_ff   <= '0;
            res_status_ff <= ffha_pkg::ST_NOSPACE;
            h_ff          <= hdr_end[AW-1:0];
         end
      end
      if (upc_ff == ffha_pkg::SP_F_EVAL) begin
         sz_ff     <= rd_sz;
         nxt_ff    <= f_nxt[AW-1:0];
         nxt_ok_ff <= nxt_lt;
      end
      if (upc_ff == ffha_pkg::SP_RSP && rsp_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule
